/* hw/rtl/bmw_pkg.sv */
package bmw_pkg;

    // default build limits
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 1024;
    localparam int MAX_DISTANCE_DEF = 4;

    // register values after reset
    localparam int WIDTH_RESET    = 500;
    localparam int HEIGHT_RESET   = 500;
    localparam int DISTANCE_RESET = 1;

    // register and field widths
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_DIST_W = 3;
    localparam int CFG_MODE_W = 2;
    localparam int PIX_W      = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [PIX_W-1:0] PIXEL_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIXEL_BLACK = 8'd0;

    // eight neighbors, center excluded
    localparam int NB = 8;

    typedef enum logic [1:0]
    {
        REG_WIDTH,
        REG_HEIGHT,
        REG_DISTANCE,
        REG_MODE
    } reg_idx_t;

    typedef enum logic [CFG_MODE_W-1:0]
    {
        MODE_ERODE,
        MODE_DILATE,
        MODE_BOUNDARY
    } mode_t;

    typedef enum logic
    {
        OP_PIXEL,
        OP_FLUSH
    } op_t;

    // position of a tap relative to the window center
    typedef enum logic [1:0]
    {
        POS_LOW,
        POS_MID,
        POS_HIGH
    } pos_t;

    localparam pos_t NB_ROW [NB] = '{POS_LOW, POS_LOW, POS_LOW, POS_MID,
                                     POS_MID, POS_HIGH, POS_HIGH, POS_HIGH};
    localparam pos_t NB_COL [NB] = '{POS_LOW, POS_MID, POS_HIGH, POS_LOW,
                                     POS_HIGH, POS_LOW, POS_MID, POS_HIGH};

    typedef struct packed
    {
        logic             operation;
        logic [PIX_W-1:0] pixel_value;
    } pixel_item_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] output_pixel;
        logic             end_of_frame;
    } result_item_t;

    typedef struct packed
    {
        logic                  restart;
        logic [CFG_MODE_W-1:0] mode;
    } cfg_ctrl_t;

    // width of a row slot index; the store keeps a power of two of slots covering the live rows
    function automatic int slot_w(input int max_distance);
        return $clog2(3 * max_distance + 1);
    endfunction

    function automatic int lat_w(input int max_width, input int max_distance);
        return $clog2(max_distance * (max_width + 1) + 1);
    endfunction

endpackage

/* hw/rtl/bmw_store.sv */
module bmw_store #(
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_bit,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_bit
);

    logic mem [2**AW];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
        if (rd_en)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

/* hw/rtl/bmw_cfg.sv */
module bmw_cfg #(
    parameter int MAX_WIDTH    = bmw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = bmw_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_DISTANCE = bmw_pkg::MAX_DISTANCE_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int DW = $clog2(MAX_DISTANCE + 1),
    localparam int LW = bmw_pkg::lat_w(MAX_WIDTH, MAX_DISTANCE)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bmw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bmw_pkg::APB_DATA_W-1:0]  prdata,
    output logic [CW-1:0]                   wm1,
    output logic [RW-1:0]                   hm1,
    output logic [DW-1:0]                   distance,
    output logic [LW-1:0]                   lat,
    output bmw_pkg::cfg_ctrl_t              ctrl
);

    localparam int WW = CW + 1;
    localparam int PW = DW + WW;
    localparam int W_RST = (bmw_pkg::WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : bmw_pkg::WIDTH_RESET;
    localparam int H_RST = (bmw_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : bmw_pkg::HEIGHT_RESET;
    localparam int D_RST = (bmw_pkg::DISTANCE_RESET > MAX_DISTANCE) ?
                           MAX_DISTANCE : bmw_pkg::DISTANCE_RESET;
    localparam logic [CW-1:0] WM1_RST = CW'(W_RST - 1);
    localparam logic [RW-1:0] HM1_RST = RW'(H_RST - 1);
    localparam logic [DW-1:0] DIST_RST = DW'(D_RST);
    localparam logic [LW-1:0] LAT_RST = LW'(D_RST * (W_RST + 1));

    logic [bmw_pkg::CFG_SIZE_W-1:0] width_raw_reg, width_raw_next;
    logic [bmw_pkg::CFG_SIZE_W-1:0] height_raw_reg, height_raw_next;
    logic [bmw_pkg::CFG_DIST_W-1:0] dist_raw_reg, dist_raw_next;
    logic [bmw_pkg::CFG_MODE_W-1:0] mode_reg, mode_next;
    logic [CW-1:0]                  wm1_reg, wm1_next;
    logic [RW-1:0]                  hm1_reg, hm1_next;
    logic [DW-1:0]                  dist_reg, dist_next;
    logic [LW-1:0]                  lat_reg, lat_next;
    logic [WW-1:0]                  w_plus;
    logic [PW-1:0]                  lat_prod;
    logic                           wr;
    logic                           restart;
    bmw_pkg::reg_idx_t              idx;

    // size register saturated to 1 .. limit, returned minus one
    function automatic int size_m1(input logic [bmw_pkg::CFG_SIZE_W-1:0] v,
                                   input int limit);
        int r;
        if (v == '0)
        begin
            r = 0;
        end
        else if (int'(v) > limit)
        begin
            r = limit - 1;
        end
        else
        begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

    assign wr  = psel & penable & pwrite;
    assign idx = bmw_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        width_raw_next  = width_raw_reg;
        height_raw_next = height_raw_reg;
        dist_raw_next   = dist_raw_reg;
        mode_next       = mode_reg;
        wm1_next        = wm1_reg;
        hm1_next        = hm1_reg;
        dist_next       = dist_reg;
        restart         = 1'b0;
        if (wr)
        begin
            unique case (idx)
                bmw_pkg::REG_WIDTH:
                begin
                    width_raw_next = pwdata[bmw_pkg::CFG_SIZE_W-1:0];
                    wm1_next = CW'(size_m1(pwdata[bmw_pkg::CFG_SIZE_W-1:0], MAX_WIDTH));
                    restart  = 1'b1;
                end
                bmw_pkg::REG_HEIGHT:
                begin
                    height_raw_next = pwdata[bmw_pkg::CFG_SIZE_W-1:0];
                    hm1_next = RW'(size_m1(pwdata[bmw_pkg::CFG_SIZE_W-1:0], MAX_HEIGHT));
                    restart  = 1'b1;
                end
                bmw_pkg::REG_DISTANCE:
                begin
                    dist_raw_next = pwdata[bmw_pkg::CFG_DIST_W-1:0];
                    if (int'(pwdata[bmw_pkg::CFG_DIST_W-1:0]) > MAX_DISTANCE)
                    begin
                        dist_next = DW'(MAX_DISTANCE);
                    end
                    else
                    begin
                        dist_next = DW'(pwdata[bmw_pkg::CFG_DIST_W-1:0]);
                    end
                    restart = 1'b1;
                end
                bmw_pkg::REG_MODE:
                begin
                    mode_next = pwdata[bmw_pkg::CFG_MODE_W-1:0];
                end
            endcase
        end
        // latency d*w + d tracks the new geometry at the write edge
        w_plus   = WW'(wm1_next) + WW'(2);
        lat_prod = PW'(dist_next) * PW'(w_plus);
        lat_next = LW'(lat_prod);
    end

    always_comb
    begin
        unique case (idx)
            bmw_pkg::REG_WIDTH:    prdata = bmw_pkg::APB_DATA_W'(width_raw_reg);
            bmw_pkg::REG_HEIGHT:   prdata = bmw_pkg::APB_DATA_W'(height_raw_reg);
            bmw_pkg::REG_DISTANCE: prdata = bmw_pkg::APB_DATA_W'(dist_raw_reg);
            bmw_pkg::REG_MODE:     prdata = bmw_pkg::APB_DATA_W'(mode_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= bmw_pkg::CFG_SIZE_W'(bmw_pkg::WIDTH_RESET);
            height_raw_reg <= bmw_pkg::CFG_SIZE_W'(bmw_pkg::HEIGHT_RESET);
            dist_raw_reg   <= bmw_pkg::CFG_DIST_W'(bmw_pkg::DISTANCE_RESET);
            mode_reg       <= bmw_pkg::MODE_ERODE;
            wm1_reg        <= WM1_RST;
            hm1_reg        <= HM1_RST;
            dist_reg       <= DIST_RST;
            lat_reg        <= LAT_RST;
        end
        else
        begin
            width_raw_reg  <= width_raw_next;
            height_raw_reg <= height_raw_next;
            dist_raw_reg   <= dist_raw_next;
            mode_reg       <= mode_next;
            wm1_reg        <= wm1_next;
            hm1_reg        <= hm1_next;
            dist_reg       <= dist_next;
            lat_reg        <= lat_next;
        end
    end

    assign wm1          = wm1_reg;
    assign hm1          = hm1_reg;
    assign distance     = dist_reg;
    assign lat          = lat_reg;
    assign ctrl.restart = restart;
    assign ctrl.mode    = mode_reg;

endmodule

/* hw/rtl/bmw_scan.sv */
module bmw_scan #(
    parameter int MAX_WIDTH    = bmw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = bmw_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_DISTANCE = bmw_pkg::MAX_DISTANCE_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int DW = $clog2(MAX_DISTANCE + 1),
    localparam int LW = bmw_pkg::lat_w(MAX_WIDTH, MAX_DISTANCE),
    localparam int SB = bmw_pkg::slot_w(MAX_DISTANCE),
    localparam int AW = SB + CW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    input  bmw_pkg::pixel_item_t             pixel_data,
    output logic                             pixel_stall,
    input  logic                             take,
    input  logic [CW-1:0]                    wm1,
    input  logic [RW-1:0]                    hm1,
    input  logic [DW-1:0]                    distance,
    input  logic [LW-1:0]                    lat,
    input  logic                             restart,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic                             wr_bit,
    output logic                             s1_valid,
    output logic                             s1_eof,
    output logic [bmw_pkg::NB-1:0][AW-1:0]   rd_addr
);

    localparam int QW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CMPW = (QW > LW) ? QW : LW;
    localparam int XC   = ((CW > DW) ? CW : DW) + 1;
    localparam int XR   = ((RW > DW) ? RW : DW) + 1;
    localparam int RXW  = (RW > SB) ? RW : SB;

    logic [CW-1:0] ic_reg, ic_next;
    logic [RW-1:0] ir_reg, ir_next;
    logic [CW-1:0] oc_reg, oc_next;
    logic [RW-1:0] or_reg, or_next;
    logic [QW-1:0] q_reg, q_next;
    logic          fid_reg, fid_next;
    logic          s1_valid_reg;
    logic          s1_eof_reg;
    logic [bmw_pkg::NB-1:0][AW-1:0] rd_addr_reg, addr_next;

    logic          s1_load;
    logic          accept;
    logic          is_pix;
    logic          emit;
    logic          last_in;
    logic          last_out;
    logic [XC-1:0] oc_x, dc_x, wm1_x, csum;
    logic [XR-1:0] or_x, dr_x, hm1_x, rsum;
    logic [CW-1:0] col_l, col_h;
    logic [RW-1:0] row_l, row_h;

    function automatic logic [SB-1:0] slot_of(input logic [RW-1:0] r);
        logic [RXW-1:0] e;
        e = RXW'(r);
        return e[SB-1:0];
    endfunction

    // pipeline handshake
    assign s1_load     = !s1_valid_reg | take;
    assign pixel_stall = !s1_load;
    assign accept      = pixel_valid & s1_load;

    assign is_pix   = (pixel_data.operation == bmw_pkg::OP_PIXEL) && !fid_reg;
    assign last_in  = (ic_reg == wm1) && (ir_reg == hm1);
    assign last_out = (oc_reg == wm1) && (or_reg == hm1);
    assign emit     = is_pix ? (CMPW'(q_reg) >= CMPW'(lat)) : fid_reg;

    // store write of the incoming pixel
    assign wr_en   = accept & is_pix;
    assign wr_addr = {slot_of(ir_reg), ic_reg};
    assign wr_bit  = (pixel_data.pixel_value == bmw_pkg::PIXEL_WHITE);

    // position counters
    always_comb
    begin
        ic_next  = ic_reg;
        ir_next  = ir_reg;
        oc_next  = oc_reg;
        or_next  = or_reg;
        q_next   = q_reg;
        fid_next = fid_reg;
        if (restart)
        begin
            ic_next  = '0;
            ir_next  = '0;
            oc_next  = '0;
            or_next  = '0;
            q_next   = '0;
            fid_next = 1'b0;
        end
        else if (accept)
        begin
            if (is_pix)
            begin
                if (last_in)
                begin
                    ic_next  = '0;
                    ir_next  = '0;
                    q_next   = '0;
                    fid_next = 1'b1;
                end
                else if (ic_reg == wm1)
                begin
                    ic_next = '0;
                    ir_next = ir_reg + 1'b1;
                    q_next  = q_reg + 1'b1;
                end
                else
                begin
                    ic_next = ic_reg + 1'b1;
                    q_next  = q_reg + 1'b1;
                end
            end
            if (emit)
            begin
                if (last_out)
                begin
                    oc_next  = '0;
                    or_next  = '0;
                    fid_next = 1'b0;
                end
                else if (oc_reg == wm1)
                begin
                    oc_next = '0;
                    or_next = or_reg + 1'b1;
                end
                else
                begin
                    oc_next = oc_reg + 1'b1;
                end
            end
        end
    end

    // neighbor coordinates clamped to the frame
    always_comb
    begin
        oc_x  = XC'(oc_reg);
        dc_x  = XC'(distance);
        wm1_x = XC'(wm1);
        csum  = oc_x + dc_x;
        col_l = (oc_x >= dc_x) ? CW'(oc_x - dc_x) : '0;
        col_h = (csum > wm1_x) ? wm1 : CW'(csum);

        or_x  = XR'(or_reg);
        dr_x  = XR'(distance);
        hm1_x = XR'(hm1);
        rsum  = or_x + dr_x;
        row_l = (or_x >= dr_x) ? RW'(or_x - dr_x) : '0;
        row_h = (rsum > hm1_x) ? hm1 : RW'(rsum);
    end

    always_comb
    begin
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        for (int k = 0; k < bmw_pkg::NB; k++)
        begin
            case (bmw_pkg::NB_ROW[k])
                bmw_pkg::POS_LOW:  r = row_l;
                bmw_pkg::POS_MID:  r = or_reg;
                default:           r = row_h;
            endcase
            case (bmw_pkg::NB_COL[k])
                bmw_pkg::POS_LOW:  c = col_l;
                bmw_pkg::POS_MID:  c = oc_reg;
                default:           c = col_h;
            endcase
            addr_next[k] = {slot_of(r), c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg       <= '0;
            ir_reg       <= '0;
            oc_reg       <= '0;
            or_reg       <= '0;
            q_reg        <= '0;
            fid_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            ic_reg  <= ic_next;
            ir_reg  <= ir_next;
            oc_reg  <= oc_next;
            or_reg  <= or_next;
            q_reg   <= q_next;
            fid_reg <= fid_next;
            if (s1_load)
            begin
                s1_valid_reg <= accept & emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_eof_reg  <= last_out;
            rd_addr_reg <= addr_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_eof   = s1_eof_reg;
    assign rd_addr  = rd_addr_reg;

endmodule

/* hw/rtl/bmw_out.sv */
module bmw_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    input  logic                              s1_eof,
    input  logic [bmw_pkg::NB-1:0]            nb_bits,
    input  logic [bmw_pkg::CFG_MODE_W-1:0]    mode,
    input  logic                              result_stall,
    output logic                              result_valid,
    output bmw_pkg::result_item_t             result_data,
    output logic                              take
);

    logic                  s2_valid_reg;
    logic                  s2_eof_reg;
    logic                  result_valid_reg;
    bmw_pkg::result_item_t result_data_reg;
    bmw_pkg::result_item_t result_next;
    logic                  out_load;
    logic                  nb_all;
    logic                  nb_any;
    logic                  white;

    assign out_load = !result_valid_reg | !result_stall;
    assign take     = !s2_valid_reg | out_load;

    assign nb_all = &nb_bits;
    assign nb_any = |nb_bits;

    always_comb
    begin
        case (bmw_pkg::mode_t'(mode))
            bmw_pkg::MODE_ERODE:  white = nb_all;
            bmw_pkg::MODE_DILATE: white = nb_any;
            default:              white = nb_any & !nb_all;
        endcase
        result_next.output_pixel = white ? bmw_pkg::PIXEL_WHITE : bmw_pkg::PIXEL_BLACK;
        result_next.end_of_frame = s2_eof_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (out_load)
            begin
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_eof_reg <= s1_eof;
        end
        if (out_load)
        begin
            result_data_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

/* hw/rtl/binary_morphology_window.sv */
// pipeline: neighbor addresses (stage one), store bits (stage two), then the result
// throughput: one item per clock unless stalled, with one store copy read per neighbor
// reset: control state, position counters and valid flags return to defaults at once
// the row store is not cleared after reset; a frame only reads what it has written itself
module binary_morphology_window #(
    parameter int MAX_WIDTH    = bmw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = bmw_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_DISTANCE = bmw_pkg::MAX_DISTANCE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel channel
    input  logic                            pixel_valid,
    input  bmw_pkg::pixel_item_t            pixel_data,
    output logic                            pixel_stall,
    // result channel
    output logic                            result_valid,
    output bmw_pkg::result_item_t           result_data,
    input  logic                            result_stall,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bmw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bmw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_DISTANCE + 1);
    localparam int LW = bmw_pkg::lat_w(MAX_WIDTH, MAX_DISTANCE);
    localparam int SB = bmw_pkg::slot_w(MAX_DISTANCE);
    localparam int AW = SB + CW;

    // effective geometry: width and height minus one, distance, latency d*w + d
    logic [CW-1:0]                  wm1;
    logic [RW-1:0]                  hm1;
    logic [DW-1:0]                  distance;
    logic [LW-1:0]                  lat;
    bmw_pkg::cfg_ctrl_t             ctrl;

    // one write port shared by all neighbor stores
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic                           wr_bit;

    // stage one: emitting item with its eight neighbor addresses
    logic                           s1_valid;
    logic                           s1_eof;
    logic [bmw_pkg::NB-1:0][AW-1:0] rd_addr;
    logic [bmw_pkg::NB-1:0]         nb_bits;
    logic                           take;

    assign pready = 1'b1;

    // register file; a geometry write restarts the frame
    bmw_cfg #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_DISTANCE (MAX_DISTANCE)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .wm1      (wm1),
        .hm1      (hm1),
        .distance (distance),
        .lat      (lat),
        .ctrl     (ctrl)
    );

    // raster counters: writes the white bit of each pixel and, once the
    // input is a full latency ahead (or the frame is draining), registers
    // the clamped neighbor addresses of the next output position
    bmw_scan #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_DISTANCE (MAX_DISTANCE)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_data  (pixel_data),
        .pixel_stall (pixel_stall),
        .take        (take),
        .wm1         (wm1),
        .hm1         (hm1),
        .distance    (distance),
        .lat         (lat),
        .restart     (ctrl.restart),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_bit      (wr_bit),
        .s1_valid    (s1_valid),
        .s1_eof      (s1_eof),
        .rd_addr     (rd_addr)
    );

    // one copy of the white-bit store per neighbor, addressed by
    // {row slot, column}; the write lands no later than the edge that registers the read
    // addresses of the item that needs it, so no bypass is required
    for (genvar k = 0; k < bmw_pkg::NB; k++)
    begin : g_store
        bmw_store #(
            .AW (AW)
        ) u_store (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_bit  (wr_bit),
            .rd_en   (take),
            .rd_addr (rd_addr[k]),
            .rd_bit  (nb_bits[k])
        );
    end

    // mode test on the eight bits and the result register with its transfer control
    bmw_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_eof       (s1_eof),
        .nb_bits      (nb_bits),
        .mode         (ctrl.mode),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (result_data),
        .take         (take)
    );

endmodule

/* bench/window_checker.sv */
module window_checker
    import bmw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    input  pixel_item_t           pixel_data,
    input  logic                  pixel_stall,
    input  logic                  result_valid,
    input  result_item_t          result_data,
    input  logic                  result_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int unsigned           mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = (2 * MAX_DISTANCE_DEF + 1) * MAX_WIDTH_DEF;
    localparam int SHOW_MAX    = 10;

    // register copies
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;
    logic [CFG_DIST_W-1:0] dist_reg;
    logic [CFG_MODE_W-1:0] mode_reg;

    // white bits by linear pixel index, plus raster positions
    bit white_mem [STORE_DEPTH];
    int in_col;
    int in_row;
    int out_col;
    int out_row;
    bit frame_full;

    result_item_t due_results [$];
    result_item_t want;

    function automatic int clip_size(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int clamp_coord(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int white_neighbors(input int w, input int h, input int d);
        int n;
        int x;
        int y;
        n = 0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                if (dx != 0 || dy != 0)
                begin
                    x = clamp_coord(out_col + dx * d, w - 1);
                    y = clamp_coord(out_row + dy * d, h - 1);
                    n += white_mem[(y * w + x) % STORE_DEPTH];
                end
            end
        end
        return n;
    endfunction

    // result at the output position, then advance it
    function automatic result_item_t emit_result(input int w, input int h, input int d);
        result_item_t r;
        int n;
        bit lit;
        bit last;
        n = white_neighbors(w, h, d);
        if (mode_reg == MODE_ERODE)
            lit = (n == NB);
        else if (mode_reg == MODE_DILATE)
            lit = (n > 0);
        else
            lit = (n > 0 && n < NB);
        last = (out_row == h - 1 && out_col == w - 1);
        r.output_pixel = lit ? PIXEL_WHITE : PIXEL_BLACK;
        r.end_of_frame = last;
        if (last)
        begin
            out_col = 0;
            out_row = 0;
            frame_full = 1'b0;
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        return r;
    endfunction

    task automatic window_step(input pixel_item_t item);
        int w;
        int h;
        int d;
        int lat;
        int q;
        w = clip_size(int'(width_reg), MAX_WIDTH_DEF);
        h = clip_size(int'(height_reg), MAX_HEIGHT_DEF);
        d = (dist_reg > MAX_DISTANCE_DEF) ? MAX_DISTANCE_DEF : int'(dist_reg);
        lat = d * w + d;
        if (item.operation == OP_PIXEL && !frame_full)
        begin
            q = in_row * w + in_col;
            white_mem[q % STORE_DEPTH] = (item.pixel_value == PIXEL_WHITE);
            if (q == w * h - 1)
            begin
                frame_full = 1'b1;
                in_col = 0;
                in_row = 0;
            end
            else if (in_col + 1 >= w)
            begin
                in_col = 0;
                in_row++;
            end
            else
                in_col++;
            if (q >= lat)
                due_results.push_back(emit_result(w, h, d));
        end
        else if (frame_full)
            due_results.push_back(emit_result(w, h, d));
    endtask

    task automatic restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_full = 1'b0;
    endtask

    task automatic apply_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        case (reg_idx_t'(addr[APB_ADDR_W-1:2]))
            REG_WIDTH:
            begin
                width_reg = data[CFG_SIZE_W-1:0];
                restart_frame();
            end
            REG_HEIGHT:
            begin
                height_reg = data[CFG_SIZE_W-1:0];
                restart_frame();
            end
            REG_DISTANCE:
            begin
                dist_reg = data[CFG_DIST_W-1:0];
                restart_frame();
            end
            REG_MODE: mode_reg = data[CFG_MODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic flag(input string msg);
        if (mismatches < SHOW_MAX)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg = CFG_SIZE_W'(WIDTH_RESET);
            height_reg = CFG_SIZE_W'(HEIGHT_RESET);
            dist_reg = CFG_DIST_W'(DISTANCE_RESET);
            mode_reg = MODE_ERODE;
            restart_frame();
            due_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                    flag($sformatf("unexpected result: pixel %0d eof %0b",
                                   result_data.output_pixel, result_data.end_of_frame));
                else
                begin
                    want = due_results.pop_front();
                    if (want.output_pixel !== result_data.output_pixel ||
                        want.end_of_frame !== result_data.end_of_frame)
                        flag($sformatf("result mismatch: expected pixel %0d eof %0b, got pixel %0d eof %0b",
                                       want.output_pixel, want.end_of_frame,
                                       result_data.output_pixel, result_data.end_of_frame));
                end
            end
            if (pixel_valid && !pixel_stall)
                window_step(pixel_data);
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
        end
        outstanding <= due_results.size();
    end

endmodule

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmw_pkg::*;

    // quiet cycles added once no predicted result is outstanding
    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 1000000;

    // raw register values outside the legal range, used to hit saturation
    localparam int SIZE_ALL_ONES = (1 << CFG_SIZE_W) - 1;
    localparam int DIST_ALL_ONES = (1 << CFG_DIST_W) - 1;
    // mode code with no name in the package, behaves as boundary
    localparam logic [CFG_MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  pixel_valid;
    pixel_item_t           pixel_data;
    logic                  pixel_stall;
    logic                  result_valid;
    result_item_t          result_data;
    logic                  result_stall;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned mismatches;
    int          outstanding;
    int          cycles;

    // sender burst state and the geometry last written, needed to size the drain
    int burst_left;
    int geo_w;
    int geo_h;
    int geo_d;
    int useful;

    binary_morphology_window u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_data   (pixel_data),
        .pixel_stall  (pixel_stall),
        .result_valid (result_valid),
        .result_data  (result_data),
        .result_stall (result_stall),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    window_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_data   (pixel_data),
        .pixel_stall  (pixel_stall),
        .result_valid (result_valid),
        .result_data  (result_data),
        .result_stall (result_stall),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cycle count doubles as the run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern, rotating through four regimes chosen by bits 10:9 of the cycle count:
    // never stall, light random stall, heavy random stall, regular short stall runs
    always @(posedge clk)
    begin
        case (cycles[10:9])
            2'd0: result_stall <= 1'b0;
            2'd1: result_stall <= ($urandom_range(0, 3) == 0);
            2'd2: result_stall <= $urandom_range(0, 1);
            default: result_stall <= (cycles[2:0] >= 3'd5);
        endcase
    end

    function automatic int clip_size(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // white with the given percentage, else black, one below white, or any non-white value
    function automatic logic [PIX_W-1:0] pick_pixel(input int white_pct);
        if ($urandom_range(0, 99) < white_pct)
            return PIXEL_WHITE;
        case ($urandom_range(0, 3))
            0: return PIXEL_BLACK;
            1: return PIXEL_WHITE - 1'b1;
            default: return PIX_W'($urandom_range(0, 254));
        endcase
    endfunction

    // one pixel-channel transfer; bursts of random length separated by random gaps
    task automatic push_item(input op_t op, input logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // only drop valid when there really is a gap, never lower and raise in one step
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        pixel_valid <= 1'b1;
        pixel_data.operation <= op;
        pixel_data.pixel_value <= pix;
        do @(posedge clk); while (pixel_stall);
        burst_left--;
    endtask

    // stop sending and hold off until every predicted result has been seen
    task automatic wait_quiet(input int extra);
        pixel_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (extra) @(posedge clk);
    endtask

    // setup cycle then access cycle; the register takes the value at the access edge
    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WIDTH: geo_w = int'(value[CFG_SIZE_W-1:0]);
            REG_HEIGHT: geo_h = int'(value[CFG_SIZE_W-1:0]);
            REG_DISTANCE: geo_d = int'(value[CFG_DIST_W-1:0]);
            default: ;
        endcase
    endtask

    // geometry writes also restart the frame in the block
    task automatic set_window(input int unsigned w, input int unsigned h,
                              input int unsigned d, input int unsigned mode);
        wait_quiet(SETTLE);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_DISTANCE, d);
        write_reg(REG_MODE, mode);
    endtask

    // a whole frame plus exactly the drain it needs, or a cut-off frame of a few pixels;
    // noise: stray flushes mid-frame (no result), rare full pauses, pixels during the drain
    // (treated as flushes) and spare flushes after it (nothing pending)
    task automatic send_frame(input int white_pct, input bit whole);
        int w;
        int h;
        int d;
        int total;
        int count;
        int drain;
        w = clip_size(geo_w, MAX_WIDTH_DEF);
        h = clip_size(geo_h, MAX_HEIGHT_DEF);
        d = (geo_d > MAX_DISTANCE_DEF) ? MAX_DISTANCE_DEF : geo_d;
        total = w * h;
        drain = 0;
        count = whole ? total : $urandom_range(0, (total > 40) ? 40 : total - 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                push_item(OP_FLUSH, PIX_W'($urandom));
            if ($urandom_range(0, 99) == 0)
                wait_quiet(0);
            push_item(OP_PIXEL, pick_pixel(white_pct));
        end
        if (whole)
        begin
            // outputs still inside the block once the frame is in
            drain = (d * w + d < total) ? d * w + d : total;
            for (int i = 0; i < drain; i++)
                push_item(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH, PIX_W'($urandom));
            repeat ($urandom_range(0, 2)) push_item(OP_FLUSH, PIX_W'($urandom));
        end
        useful += count + drain;
    endtask

    initial
    begin
        int choice;
        bit last_whole;

        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        pixel_valid = 1'b0;
        pixel_data = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        useful = 0;
        geo_w = WIDTH_RESET;
        geo_h = HEIGHT_RESET;
        geo_d = DISTANCE_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // reset geometry: a few pixels, too early for any result, and a flush mid-frame
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_PIXEL, PIXEL_BLACK);
        push_item(OP_PIXEL, PIXEL_WHITE - 1'b1);
        push_item(OP_FLUSH, PIXEL_WHITE);

        // geometry write mid-frame restarts it; 3x2 erode at distance one
        set_window(3, 2, 1, MODE_ERODE);
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_PIXEL, PIXEL_WHITE >> 1);
        // drain four, one of them a pixel that only counts as a flush
        push_item(OP_FLUSH, PIXEL_BLACK);
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_FLUSH, PIXEL_WHITE);
        push_item(OP_FLUSH, PIXEL_BLACK);
        // nothing left to drain
        push_item(OP_FLUSH, PIXEL_WHITE);

        // distance zero with the unnamed mode code: every neighbor is the center
        set_window(2, 1, 0, MODE_SPARE);
        push_item(OP_PIXEL, PIXEL_WHITE);
        push_item(OP_PIXEL, PIXEL_BLACK);
        push_item(OP_FLUSH, PIXEL_BLACK);

        // latency longer than the frame, all outputs come from the drain
        set_window(2, 2, 2, MODE_DILATE);
        push_item(OP_PIXEL, PIXEL_BLACK);
        push_item(OP_PIXEL, PIXEL_BLACK);
        push_item(OP_PIXEL, PIXEL_BLACK);
        push_item(OP_PIXEL, PIXEL_WHITE);
        repeat (4) push_item(OP_FLUSH, PIXEL_BLACK);

        // --- register extremes ---
        // widest legal row, one row high
        set_window(MAX_WIDTH_DEF, 1, 1, MODE_BOUNDARY);
        send_frame(50, 1'b1);
        // zero width and oversize height saturate to a single tall column, distance capped
        set_window(0, SIZE_ALL_ONES, DIST_ALL_ONES, MODE_ERODE);
        send_frame(90, 1'b1);
        // oversize width with zero height, only a cut-off frame
        set_window(SIZE_ALL_ONES, 0, MAX_DISTANCE_DEF + 1, MODE_DILATE);
        send_frame(50, 1'b0);

        // --- random frames ---
        // mostly whole frames with random content; a cut-off frame is always followed by
        // a geometry write, a whole one may run straight into the next or change only the mode
        useful = 0;
        last_whole = 1'b0;
        while (useful < RANDOM_ITEMS)
        begin
            choice = last_whole ? $urandom_range(0, 3) : 0;
            if (choice <= 1)
                set_window(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12),
                           ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10),
                           $urandom_range(0, DIST_ALL_ONES),
                           $urandom_range(0, MODE_SPARE));
            else if (choice == 2)
            begin
                wait_quiet(SETTLE);
                write_reg(REG_MODE, $urandom_range(0, MODE_SPARE));
            end
            last_whole = ($urandom_range(0, 5) != 0);
            send_frame($urandom_range(0, 4) * 25, last_whole);
        end

        // everything predicted must have arrived, then a short quiet tail
        wait_quiet(SETTLE);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
